### rtl/trb_pkg.sv
// shared types and constants of the timestamp reorder buffer
`timescale 1ns / 1ps
package trb_pkg;
	localparam int STAMP_W = 32;
	localparam int TAG_W = 16;
	localparam int CFG_W = 32;
	localparam int STEP_W = 10;
	localparam int LEVEL_W = 7;
	localparam int MAX_RESULTS = 56;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_SYNTH_ON = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AUDIO_STEP = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VIDEO_STEP = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DRAIN_TRIGGER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DRAIN_FLOOR = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SPAN_LIMIT = 3'd5;

	typedef struct packed {
		logic audio;
		logic [STAMP_W-1:0] timestamp;
		logic [TAG_W-1:0] tag;
	} item_t;

	typedef struct packed {
		logic [TAG_W-1:0] out_tag;
		logic out_is_audio;
		logic [STAMP_W-1:0] out_decode_stamp;
		logic [STAMP_W-1:0] out_present_stamp;
		logic dropped;
		logic last;
	} result_t;

	typedef struct packed {
		logic synth_on;
		logic [STEP_W-1:0] audio_step;
		logic [STEP_W-1:0] video_step;
	} stamp_cfg_t;
endpackage

### rtl/trb_stamp.sv
// per-stream synthetic decode stamp counters
`timescale 1ns / 1ps
module trb_stamp (
	input logic clk,
	input logic arst_n,
	input trb_pkg::stamp_cfg_t cfg,
	input logic audio,
	input logic [trb_pkg::STAMP_W-1:0] stamp,
	input logic advance,
	output logic [trb_pkg::STAMP_W-1:0] decode_stamp
);
	logic [trb_pkg::STAMP_W-1:0] audio_q;
	logic [trb_pkg::STAMP_W-1:0] video_q;

	always_comb begin
		if (!cfg.synth_on) begin
			decode_stamp = stamp;
		end else if (audio) begin
			decode_stamp = audio_q;
		end else begin
			decode_stamp = video_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_q <= '0;
			video_q <= '0;
		end else if (advance && cfg.synth_on) begin
			if (audio) begin
				audio_q <= audio_q + trb_pkg::STAMP_W'(cfg.audio_step);
			end else begin
				video_q <= video_q + trb_pkg::STAMP_W'(cfg.video_step);
			end
		end
	end
endmodule

### rtl/timestamp_reorder_buffer.sv
// timestamp_reorder_buffer: sorted circular buffer in one memory, insert (or drop when full) then drain
// insertion shifts entries up one at a time, with a read state and a compare state per entry
// drain check passes through the check and tail states, then one emitted word per cycle while the output is free
// one item at a time; the item port stalls until its last word is in the output register
// reset clears count, head pointer, stamp counters and registers to defaults;
// the entry memory is not cleared, only entries below the count are ever used
`timescale 1ns / 1ps
module timestamp_reorder_buffer #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input trb_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output trb_pkg::result_t result,
	input logic wr_en,
	input logic [trb_pkg::REG_IDX_W-1:0] wr_index,
	input logic [trb_pkg::CFG_W-1:0] wr_data
);
	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > trb_pkg::LEVEL_W) ? CW : trb_pkg::LEVEL_W;
	localparam int NW = $clog2(trb_pkg::MAX_RESULTS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS_RD = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_INS_NEW = 3'd3;
	localparam logic [2:0] S_CHK = 3'd4;
	localparam logic [2:0] S_TAIL = 3'd5;
	localparam logic [2:0] S_HEAD = 3'd6;
	localparam logic [2:0] S_FIN = 3'd7;

	// configuration
	trb_pkg::stamp_cfg_t stamp_cfg_q;
	logic [trb_pkg::LEVEL_W-1:0] trigger_q;
	logic [trb_pkg::LEVEL_W-1:0] floor_q;
	logic [trb_pkg::STAMP_W-1:0] span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_cfg_q.synth_on <= 1'b1;
			stamp_cfg_q.audio_step <= trb_pkg::STEP_W'(20);
			stamp_cfg_q.video_step <= trb_pkg::STEP_W'(33);
			trigger_q <= trb_pkg::LEVEL_W'(50);
			floor_q <= trb_pkg::LEVEL_W'(10);
			span_q <= trb_pkg::STAMP_W'(5000);
		end else if (wr_en) begin
			unique case (wr_index)
				trb_pkg::REG_SYNTH_ON: stamp_cfg_q.synth_on <= wr_data[0];
				trb_pkg::REG_AUDIO_STEP: stamp_cfg_q.audio_step <= wr_data[trb_pkg::STEP_W-1:0];
				trb_pkg::REG_VIDEO_STEP: stamp_cfg_q.video_step <= wr_data[trb_pkg::STEP_W-1:0];
				trb_pkg::REG_DRAIN_TRIGGER: trigger_q <= wr_data[trb_pkg::LEVEL_W-1:0];
				trb_pkg::REG_DRAIN_FLOOR: floor_q <= wr_data[trb_pkg::LEVEL_W-1:0];
				trb_pkg::REG_SPAN_LIMIT: span_q <= wr_data[trb_pkg::STAMP_W-1:0];
				default: ;
			endcase
		end
	end

	// entry memory
	trb_pkg::item_t mem [CAPACITY];
	trb_pkg::item_t rd_q;
	trb_pkg::item_t mem_wd;
	logic mem_we;
	logic mem_re;
	logic [PW-1:0] mem_wa;
	logic [PW-1:0] mem_ra;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// control state
	logic [2:0] state_q;
	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ins_q;
	logic [NW-1:0] n_q;
	trb_pkg::item_t item_q;
	logic [trb_pkg::STAMP_W-1:0] tail_q;
	logic pend_valid_q;
	trb_pkg::result_t pend_q;
	logic out_valid_q;
	trb_pkg::result_t out_q;

	function automatic logic [PW-1:0] phys(input logic [PW-1:0] head, input logic [CW-1:0] i);
		logic [CW:0] sum;
		sum = (CW + 1)'(head) + (CW + 1)'(i);
		if (sum >= (CW + 1)'(CAPACITY)) begin
			sum = sum - (CW + 1)'(CAPACITY);
		end
		return sum[PW-1:0];
	endfunction

	logic [PW-1:0] head_inc;
	logic out_free;
	logic drain_go;
	logic drain_ok;
	logic emit;
	logic push;
	trb_pkg::result_t push_word;
	logic [trb_pkg::STAMP_W-1:0] dec_stamp;
	logic [trb_pkg::STAMP_W-1:0] span_now;

	assign head_inc = (head_q == PW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign out_free = !out_valid_q || !result_stall;
	assign span_now = tail_q - rd_q.timestamp;
	assign drain_go = (MW'(count_q) >= MW'(trigger_q)) && (count_q != '0)
		&& (MW'(count_q) >= MW'(floor_q)) && (n_q < NW'(trb_pkg::MAX_RESULTS));
	assign drain_ok = (n_q < NW'(trb_pkg::MAX_RESULTS)) && (count_q != '0)
		&& (MW'(count_q) >= MW'(floor_q)) && (span_now >= span_q);
	assign emit = (state_q == S_HEAD) && drain_ok && (!pend_valid_q || out_free);
	// the pending word goes out once the next one (or the end) is known
	assign push = pend_valid_q && out_free && (emit || state_q == S_FIN);

	always_comb begin
		push_word = pend_q;
		push_word.last = (state_q == S_FIN);
	end

	trb_stamp u_stamp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(stamp_cfg_q),
		.audio(rd_q.audio),
		.stamp(rd_q.timestamp),
		.advance(emit),
		.decode_stamp(dec_stamp)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = phys(head_q, ins_q);
		mem_ra = head_q;
		mem_wd = item_q;
		unique case (state_q)
			S_INS_RD: begin
				mem_re = 1'b1;
				mem_ra = phys(head_q, ins_q - 1'b1);
			end
			S_INS_CMP: begin
				if (!(rd_q.timestamp < item_q.timestamp)) begin
					mem_we = 1'b1;
					mem_wd = rd_q;
				end
			end
			S_INS_NEW: mem_we = 1'b1;
			S_CHK: begin
				mem_re = drain_go;
				mem_ra = phys(head_q, count_q - 1'b1);
			end
			S_TAIL: mem_re = 1'b1;
			S_HEAD: begin
				mem_re = emit;
				mem_ra = head_inc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			ins_q <= '0;
			n_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (count_q == CW'(CAPACITY)) begin
							pend_valid_q <= 1'b1;
							n_q <= NW'(1);
							state_q <= S_CHK;
						end else if (count_q == '0) begin
							n_q <= '0;
							ins_q <= '0;
							state_q <= S_INS_NEW;
						end else begin
							n_q <= '0;
							ins_q <= count_q;
							state_q <= S_INS_RD;
						end
					end
				end
				S_INS_RD: state_q <= S_INS_CMP;
				S_INS_CMP: begin
					if (rd_q.timestamp < item_q.timestamp) begin
						state_q <= S_INS_NEW;
					end else begin
						ins_q <= ins_q - 1'b1;
						state_q <= (ins_q == CW'(1)) ? S_INS_NEW : S_INS_RD;
					end
				end
				S_INS_NEW: begin
					count_q <= count_q + 1'b1;
					state_q <= S_CHK;
				end
				S_CHK: state_q <= drain_go ? S_TAIL : S_FIN;
				S_TAIL: state_q <= S_HEAD;
				S_HEAD: begin
					if (!drain_ok) begin
						state_q <= S_FIN;
					end else if (emit) begin
						pend_valid_q <= 1'b1;
						head_q <= head_inc;
						count_q <= count_q - 1'b1;
						n_q <= n_q + 1'b1;
					end
				end
				S_FIN: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			item_q <= item;
			pend_q.out_tag <= item.tag;
			pend_q.out_is_audio <= item.audio;
			pend_q.out_decode_stamp <= '0;
			pend_q.out_present_stamp <= item.timestamp;
			pend_q.dropped <= 1'b1;
			pend_q.last <= 1'b0;
		end
		if (state_q == S_TAIL) begin
			tail_q <= rd_q.timestamp;
		end
		if (emit) begin
			pend_q.out_tag <= rd_q.tag;
			pend_q.out_is_audio <= rd_q.audio;
			pend_q.out_decode_stamp <= dec_stamp;
			pend_q.out_present_stamp <= rd_q.timestamp;
			pend_q.dropped <= 1'b0;
			pend_q.last <= 1'b0;
		end
		if (push) begin
			out_q <= push_word;
		end
	end

	assign item_stall = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");
	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("pending word left behind at idle");
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_NEW |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not raise the count");
	a_emit_pops: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> count_q == $past(count_q) - 1'b1 && n_q == $past(n_q) + 1'b1)
		else $error("drain bookkeeping slipped");
endmodule
